FILE: design/md5_pkg.sv
// md5_pkg: shared constants, types and step tables for the md5_digest block
// no dependencies
package md5_pkg;

	localparam int WordWidth   = 32;
	localparam int BlockDepth  = 16;
	localparam int StepCount   = 64;

	localparam logic [31:0] InitA = 32'h67452301;
	localparam logic [31:0] InitB = 32'hefcdab89;
	localparam logic [31:0] InitC = 32'h98badcfe;
	localparam logic [31:0] InitD = 32'h10325476;
	localparam logic [7:0]  PadByte = 8'h80;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_LEN   = 6'b000100,
		ST_STEP  = 6'b001000,
		ST_ADD   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	function automatic logic [31:0] sine_k(input logic [5:0] i);
		logic [31:0] t [64];
		t = '{
			32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
			32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
			32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
			32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
			32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
			32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
			32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
			32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
			32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
			32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
			32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
			32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
			32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
			32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
			32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
			32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
		return t[i];
	endfunction

	function automatic logic [4:0] rot_s(input logic [5:0] i);
		logic [4:0] r;
		case ({i[5:4], i[1:0]})
			4'h0: r = 5'd7;   4'h1: r = 5'd12;  4'h2: r = 5'd17;  4'h3: r = 5'd22;
			4'h4: r = 5'd5;   4'h5: r = 5'd9;   4'h6: r = 5'd14;  4'h7: r = 5'd20;
			4'h8: r = 5'd4;   4'h9: r = 5'd11;  4'ha: r = 5'd16;  4'hb: r = 5'd23;
			4'hc: r = 5'd6;   4'hd: r = 5'd10;  4'he: r = 5'd15;  4'hf: r = 5'd21;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// message word index used by step i
	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'(({2'b0, i[3:0]} * 6'd5) + 6'd1);
			2'd2: g = 4'(({2'b0, i[3:0]} * 6'd3) + 6'd5);
			2'd3: g = 4'({2'b0, i[3:0]} * 6'd7);
			default: g = 4'd0;
		endcase
		return g;
	endfunction

endpackage

FILE: design/md5_ram.sv
// md5_ram: generic single-port-write, one-read synchronous RAM, registered read
// no dependencies
module md5_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

FILE: design/md5_digest.sv
// md5_digest: streaming MD5 hash, top level
// depends on md5_pkg and md5_ram
//
// usage
//  - input channel (data_byte, byte_present, end_of_message, valid/ready):
//    one message byte per transfer; end_of_message closes the message, and a
//    transfer with byte_present low and the end mark hashes what came so far
//  - output channel (digest_word, word_number, final_word, valid/ready):
//    four transfers A, B, C, D per message, final_word high on D
//  - rate: a byte that does not fill a block is kept in the partial word
//    register or written to the block memory, and ready stays high; a byte
//    that fills a block adds the 64-step compression, one step per cycle
//    through the block memory read port, plus the first read fetch and the
//    chaining add
//  - end of message: zero fill runs one word per cycle, the length is written
//    as two words, then one or two compressions, then the four digest words
//  - the block memory has one read port; a partial word is built in a
//    register and only written when complete, so no read-modify-write races
//  - reset loads the initial chaining words and clears bit count and byte position at once
//  - a stalled receiver holds the output register; no input is taken until
//    all four digest words are transferred
module md5_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [1:0]  word_number,
	output logic        final_word
);
	import md5_pkg::*;

	localparam int AW = $clog2(BlockDepth);

	state_t      state_q;
	logic [31:0] ca_q, cb_q, cc_q, cd_q;       // chaining words
	logic [31:0] a_q, b_q, c_q, d_q;           // working words
	logic [63:0] bit_count_q, len_q;
	logic [5:0]  pos_q;                        // byte position in block
	logic [23:0] part_q;                       // lower lanes of current word
	logic [5:0]  step_q;
	logic        step_rd_q;                    // read data valid for step_q
	logic        last_q;                       // block being compressed is final
	logic        len_hi_q;
	logic [1:0]  out_cnt_q;
	logic        pad_first_q;                  // next pad word carries 0x80
	logic        pad_more_q;                   // pad block compressed, length block follows

	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [31:0]   wr_data, rd_data;

	md5_ram #(.Width(WordWidth), .Depth(BlockDepth)) u_block (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	assign in_ready = (state_q == ST_IDLE);
	logic take;
	assign take = in_valid && in_ready;

	// step datapath
	logic [31:0] f, sum, rot;
	logic [4:0]  sh;
	always_comb begin
		case (step_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sum = a_q + f + rd_data + sine_k(step_q);
		sh  = rot_s(step_q);
		rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
	end

	// memory port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q[5:2];
		wr_data = {8'h00, part_q};
		rd_addr = step_q[5:0] == 6'd0 ? msg_index(6'd0) : msg_index(step_q);
		case (state_q)
			ST_IDLE: begin
				if (take && byte_present && pos_q[1:0] == 2'd3) begin
					wr_en   = 1'b1;
					wr_data = {data_byte, part_q};
				end
			end
			ST_PAD: begin
				// first pad word carries the partial word plus 0x80
				wr_en = 1'b1;
				case (pos_q[1:0])
					2'd0: wr_data = {24'h0, PadByte};
					2'd1: wr_data = {16'h0, PadByte, part_q[7:0]};
					2'd2: wr_data = {8'h0, PadByte, part_q[15:0]};
					default: wr_data = {PadByte, part_q};
				endcase
				// later pad words are zero fill
				if (!pad_first_q) begin
					wr_data = 32'h0;
				end
			end
			ST_LEN: begin
				wr_en   = 1'b1;
				wr_addr = len_hi_q ? 4'(15) : 4'(14);
				wr_data = len_hi_q ? len_q[63:32] : len_q[31:0];
			end
			ST_STEP: rd_addr = msg_index(step_rd_q ? step_q + 6'd1 : step_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ca_q <= InitA; cb_q <= InitB; cc_q <= InitC; cd_q <= InitD;
			bit_count_q <= '0;
			pos_q       <= '0;
			step_q      <= '0;
			step_rd_q   <= 1'b0;
			last_q      <= 1'b0;
			len_hi_q    <= 1'b0;
			out_cnt_q   <= '0;
			out_valid   <= 1'b0;
			pad_first_q <= 1'b0;
			pad_more_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (byte_present) begin
							case (pos_q[1:0])
								2'd0: part_q[7:0]   <= data_byte;
								2'd1: part_q[15:8]  <= data_byte;
								2'd2: part_q[23:16] <= data_byte;
								default: part_q     <= '0;
							endcase
							bit_count_q <= bit_count_q + 64'd8;
							pos_q       <= pos_q + 6'd1;
						end
						len_q <= bit_count_q + (byte_present ? 64'd8 : 64'd0);
						last_q <= 1'b0;
						step_q <= '0;
						step_rd_q <= 1'b0;
						if (byte_present && pos_q == 6'd63) begin
							state_q <= ST_STEP;
							pad_first_q <= end_of_message;
						end else if (end_of_message) begin
							state_q     <= ST_PAD;
							pad_first_q <= 1'b1;
						end
						a_q <= ca_q; b_q <= cb_q; c_q <= cc_q; d_q <= cd_q;
					end
				end
				ST_PAD: begin
					// writes word pos_q[5:2]; the 0x80 word first, then zeros
					part_q      <= '0;
					pad_first_q <= 1'b0;
					pos_q       <= {pos_q[5:2] + 4'd1, 2'b00};
					if (pos_q[5:2] == 4'd13) begin
						state_q  <= ST_LEN;
						len_hi_q <= 1'b0;
						len_q    <= len_q;
					end else if (pos_q[5:2] == 4'd15) begin
						// 0x80 or fill reached the end: compress, pad again
						state_q <= ST_STEP;
						step_q  <= '0;
						step_rd_q <= 1'b0;
						pad_more_q <= 1'b1;
						a_q <= ca_q; b_q <= cb_q; c_q <= cc_q; d_q <= cd_q;
					end
				end
				ST_LEN: begin
					len_hi_q <= 1'b1;
					if (len_hi_q) begin
						state_q   <= ST_STEP;
						last_q    <= 1'b1;
						step_q    <= '0;
						step_rd_q <= 1'b0;
						pos_q     <= '0;
						a_q <= ca_q; b_q <= cb_q; c_q <= cc_q; d_q <= cd_q;
					end
				end
				ST_STEP: begin
					if (!step_rd_q) begin
						step_rd_q <= 1'b1;
					end else begin
						a_q <= d_q; d_q <= c_q; c_q <= b_q;
						b_q <= b_q + rot;
						step_q <= step_q + 6'd1;
						if (step_q == 6'd63) state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					ca_q <= ca_q + a_q; cb_q <= cb_q + b_q;
					cc_q <= cc_q + c_q; cd_q <= cd_q + d_q;
					step_q <= '0;
					step_rd_q <= 1'b0;
					pad_more_q <= 1'b0;
					if (last_q) begin
						state_q   <= ST_OUT;
						out_cnt_q <= '0;
						out_valid <= 1'b1;
					end else if (pad_first_q || pad_more_q) begin
						// message end pending after a full block or a pad block
						state_q <= ST_PAD;
						pos_q   <= '0;
						a_q <= ca_q + a_q; b_q <= cb_q + b_q;
						c_q <= cc_q + c_q; d_q <= cd_q + d_q;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						out_cnt_q <= out_cnt_q + 2'd1;
						if (out_cnt_q == 2'd3) begin
							out_valid   <= 1'b0;
							state_q     <= ST_IDLE;
							ca_q <= InitA; cb_q <= InitB; cc_q <= InitC; cd_q <= InitD;
							bit_count_q <= '0;
							pos_q       <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		case (out_cnt_q)
			2'd0: digest_word = ca_q;
			2'd1: digest_word = cb_q;
			2'd2: digest_word = cc_q;
			default: digest_word = cd_q;
		endcase
		word_number = out_cnt_q;
		final_word  = (out_cnt_q == 2'd3);
	end

`ifndef SYNTH
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while digest pending");
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT) else $error("digest valid outside output");
	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && final_word |=> !out_valid)
		else $error("digest ran past word D");
`endif

endmodule

FILE: dv/md5_digest_tb.sv
// md5_digest_tb: self-checking testbench for the streaming MD5 block
// depends on md5_pkg and md5_digest; an in-bench scoreboard predicts every digest word
`timescale 1ns / 100ps

module md5_digest_tb;
	import md5_pkg::*;

	localparam time ClkPeriod = 12;
	localparam int ItemTarget = 260;
	localparam int DrainCycles = 400;

	// per-step additive constants and rotate amounts, indexed by step / (round, step mod 4)
	localparam logic [31:0] StepAdd [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
	localparam int StepRot [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	typedef struct {
		logic [31:0] word;
		logic [1:0]  number;
		logic        last;
	} digest_word_t;

	// running hash predictor plus the queue of digest words still owed by the block
	class md5_scoreboard;
		logic [31:0] chain [4];
		logic [31:0] block [16];
		logic [63:0] bit_total;
		logic [5:0]  slot;
		digest_word_t owed [$];
		int mismatches;

		function new();
			mismatches = 0;
			foreach (block[i]) block[i] = '0;
			restart();
		endfunction

		function void restart();
			chain[0] = InitA;
			chain[1] = InitB;
			chain[2] = InitC;
			chain[3] = InitD;
			bit_total = '0;
			slot = '0;
		endfunction

		function void compress();
			logic [31:0] a, b, c, d, f, sum, nb;
			int g, rnd;
			a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
			for (int i = 0; i < 64; i++) begin
				rnd = i / 16;
				case (rnd)
					0: begin f = (b & c) | (~b & d); g = i; end
					1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
					2: begin f = b ^ c ^ d;          g = (3 * i + 5) % 16; end
					default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
				endcase
				sum = a + f + block[g] + StepAdd[i];
				nb = b + ((sum << StepRot[rnd * 4 + i % 4]) |
					(sum >> (32 - StepRot[rnd * 4 + i % 4])));
				a = d; d = c; c = b; b = nb;
			end
			chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		endfunction

		function void push_byte(logic [7:0] value);
			if (slot[1:0] == 2'd0)
				block[slot[5:2]] = {24'd0, value};
			else
				block[slot[5:2]] |= 32'(value) << (8 * slot[1:0]);
			slot++;
			if (slot == 6'd0)
				compress();
		endfunction

		// one accepted input transfer
		function void note_transfer(logic [7:0] value, logic present, logic eom);
			logic [63:0] length;
			digest_word_t w;
			if (present) begin
				push_byte(value);
				bit_total += 64'd8;
			end
			if (!eom)
				return;
			length = bit_total;
			push_byte(PadByte);
			while (slot != 6'd56)
				push_byte(8'h00);
			block[14] = length[31:0];
			block[15] = length[63:32];
			compress();
			for (int k = 0; k < 4; k++) begin
				w.word = chain[k];
				w.number = 2'(k);
				w.last = (k == 3);
				owed.push_back(w);
			end
			restart();
		endfunction

		// one accepted output transfer
		function void check_transfer(logic [31:0] word, logic [1:0] number, logic last);
			digest_word_t w;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digest word %h num %0d final %b", word, number, last);
				return;
			end
			w = owed.pop_front();
			if (word !== w.word || number !== w.number || last !== w.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
						w.word, w.number, w.last, word, number, last);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        byte_present = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [1:0]  word_number;
	logic        final_word;

	md5_scoreboard sb = new();
	int items_sent = 0;
	int burst_left = 0;
	bit stream_done = 1'b0;

	md5_digest dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.byte_present(byte_present),
		.end_of_message(end_of_message),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digest_word(digest_word),
		.word_number(word_number),
		.final_word(final_word)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	// receiver: cycles through free-running, a fixed stall pattern and random stalls
	int rx_phase = 0;
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		if ((rx_phase / 97) % 3 == 0)
			out_ready <= 1'b1;
		else if ((rx_phase / 97) % 3 == 1)
			out_ready <= (rx_phase % 7) > 3;
		else
			out_ready <= $urandom_range(0, 3) == 0;
	end

	// output monitor: a transfer happens where valid and ready meet at the edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_transfer(digest_word, word_number, final_word);
	end

	// one input transfer, preceded by a random gap between bursts
	task automatic send_item(logic [7:0] value, logic present, logic eom);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= value;
		byte_present <= present;
		end_of_message <= eom;
		do @(posedge clk); while (!in_ready);
		sb.note_transfer(value, present, eom);
		if (present || eom)
			items_sent++;
	endtask

	// a whole message; either the last byte carries the end mark or a bare end follows
	task automatic send_message(int len, bit bare_end, bit noisy);
		for (int i = 0; i < len; i++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
		end
		if (bare_end || len == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int len;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, ignored item, byte extremes, "abc", byte then bare end, ignored item, single byte
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h80, 1'b0, 1'b0);
		send_item(8'h7f, 1'b1, 1'b1);

		// random messages; some lengths straddle the one/two padding block boundary
		while (items_sent < ItemTarget) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: len = $urandom_range(0, 12);
				5, 6: len = $urandom_range(13, 40);
				7, 8: len = $urandom_range(52, 68);
				default: len = $urandom_range(110, 135);
			endcase
			// keep the total close to the item target
			if (len > ItemTarget - items_sent)
				len = ItemTarget - items_sent;
			send_message(len, $urandom_range(0, 3) == 0, 1'b1);
		end
		in_valid <= 1'b0;
		stream_done = 1'b1;
	end

	// completion: drain outstanding digest words, then a short quiet period
	initial begin
		wait (stream_done);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
